// File: rtl/core/srx_pkg.sv
// ============================================================================
// srx_pkg
// Shared types, codes and helper functions for the serial frame receiver.
// ============================================================================
package srx_pkg;

   localparam logic [7:0]  PREAMBLE_RESET    = 8'h7E;
   localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd248;
   localparam logic [31:0] CRC_POLY          = 32'h04C11DB7;
   localparam int          FIFO_DEPTH        = 4;
   localparam int          FIFO_PTR_W        = $clog2(FIFO_DEPTH);
   localparam int          FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

   // Configuration register indexes
   localparam logic CSR_PREAMBLE    = 1'b0;
   localparam logic CSR_MAX_PAYLOAD = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_FRAME    = 2'd1;
   localparam logic [1:0] KIND_SIZE_ERR = 2'd2;

   // Header byte positions
   localparam logic [7:0] HDR_SIZE_POS = 8'd4;
   localparam logic [7:0] HDR_DEST_POS = 8'd5;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_HEADER,
      PH_PAYLOAD
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] frame_crc;
      logic [31:0] computed_crc;
      logic        crc_ok;
      logic [7:0]  frame_size;
      logic [7:0]  dest_addr;
      logic [7:0]  src_addr;
      logic        last;
   } result_type;

   // Up to two results produced by one bit, in delivery order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // One MSB-first CRC-32 step for a single data bit.
   function automatic logic [31:0] crc_bit_step(input logic [31:0] crc, input logic data);
      logic [31:0] shifted;
      shifted = {crc[30:0], 1'b0};
      return (crc[31] ^ data) ? (shifted ^ CRC_POLY) : shifted;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// File: rtl/core/serial_frame_receiver_crc32_top.sv
// A bit is held in the input register until the queue has room; its results
// are then written into the result queue, and rsp offers them from there.
// Throughput: one bit per cycle; the four-item result queue sets when req stalls.
// A new bit is stalled only while the held bit waits for room for two items.
// Reset is synchronous and active high: hunting, all counters and CRCs zero,
// preamble 0x7E and payload limit 248; the queue empties.
// ============================================================================
// serial_frame_receiver_crc32_top
// Synchronous serial deframer with CRC-32 check, one data bit per item.
// ============================================================================
module serial_frame_receiver_crc32_top (
   input  logic        clock,
   input  logic        reset,
   // Input channel: one sampled data bit per item.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_data_bit,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [31:0] rsp_frame_crc,
   output logic [31:0] rsp_computed_crc,
   output logic        rsp_crc_ok,
   output logic [7:0]  rsp_frame_size,
   output logic [7:0]  rsp_dest_addr,
   output logic [7:0]  rsp_src_addr,
   output logic        rsp_last,
   // Configuration write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   // The input register holds one bit. It is handed to the deframer in the
   // following cycle provided the result queue can take two items, which is
   // the most a single bit can produce (the last payload byte plus the frame
   // result). While the deframer may take it, a new bit is accepted in the
   // same cycle, so the block sustains one bit per cycle.
   logic bit_ff, bit_in;
   logic valid_ff, valid_in;
   logic [7:0] preamble_ff, preamble_in;
   logic [7:0] max_payload_ff, max_payload_in;

   logic                room;
   logic                consume;
   logic                accept;
   srx_pkg::push_type   push;
   srx_pkg::result_type out_item;
   logic                out_pop;

   assign consume   = valid_ff && room;
   assign req_stall = valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      bit_in   = bit_ff;
      if (accept) begin
         valid_in = 1'b1;
         bit_in   = req_data_bit;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   // Configuration registers are always ready; writes must arrive only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   always_comb begin
      preamble_in    = preamble_ff;
      max_payload_in = max_payload_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            srx_pkg::CSR_PREAMBLE:    preamble_in    = csr_data;
            srx_pkg::CSR_MAX_PAYLOAD: max_payload_in = csr_data;
            default:                  preamble_in    = preamble_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         preamble_ff    <= srx_pkg::PREAMBLE_RESET;
         max_payload_ff <= srx_pkg::MAX_PAYLOAD_RESET;
      end else begin
         valid_ff       <= valid_in;
         preamble_ff    <= preamble_in;
         max_payload_ff <= max_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   // The deframer advances its state by one bit per consumed item and
   // reports any results straight into the queue.
   srx_deframer u_deframer (
      .clock       (clock),
      .reset       (reset),
      .step_en     (consume),
      .step_bit    (bit_ff),
      .preamble    (preamble_ff),
      .max_payload (max_payload_ff),
      .push        (push)
   );

   // The queue decouples the two sides: bits keep flowing while finished
   // results wait for the receiver.
   assign out_pop = rsp_valid && !rsp_stall;

   srx_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_pop   (out_pop),
      .out_item  (out_item)
   );

   assign rsp_kind         = out_item.kind;
   assign rsp_data_byte    = out_item.data_byte;
   assign rsp_frame_crc    = out_item.frame_crc;
   assign rsp_computed_crc = out_item.computed_crc;
   assign rsp_crc_ok       = out_item.crc_ok;
   assign rsp_frame_size   = out_item.frame_size;
   assign rsp_dest_addr    = out_item.dest_addr;
   assign rsp_src_addr     = out_item.src_addr;
   assign rsp_last         = out_item.last;

endmodule

// File: rtl/core/srx_deframer.sv
// ============================================================================
// srx_deframer
// Frame state machine: preamble hunt, header capture, payload and CRC-32.
// ============================================================================
module srx_deframer (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic              step_bit,
   input  logic [7:0]        preamble,
   input  logic [7:0]        max_payload,
   output srx_pkg::push_type push
);

   srx_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  window_ff, window_in;
   logic [2:0]  bit_count_ff, bit_count_in;
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  partial_ff, partial_in;
   logic [31:0] crc_rx_ff, crc_rx_in;
   logic [31:0] crc_run_ff, crc_run_in;
   logic [7:0]  size_ff, size_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  src_ff, src_in;

   logic [7:0]  window_shift;
   logic [7:0]  byte_val;
   logic        byte_done;
   logic        crc_active;
   logic [31:0] crc_step;
   logic [7:0]  payload_len;
   logic        size_bad;
   logic        in_header;
   logic        in_payload;

   assign in_header    = (phase_ff == srx_pkg::PH_HEADER);
   assign in_payload   = (phase_ff == srx_pkg::PH_PAYLOAD);
   assign window_shift = {window_ff[6:0], step_bit};
   assign byte_val     = {partial_ff[6:0], step_bit};
   assign byte_done    = (bit_count_ff == 3'd7);
   // Destination, source and payload bytes feed the CRC one bit at a time.
   assign crc_active   = in_payload || (in_header && byte_count_ff >= srx_pkg::HDR_DEST_POS);
   assign crc_step     = srx_pkg::crc_bit_step(crc_run_ff, step_bit);
   assign payload_len  = size_ff - 8'd2;
   assign size_bad     = (size_ff < 8'd2) || (payload_len > max_payload);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step_en) begin
         unique case (phase_ff)
            srx_pkg::PH_HEADER: begin
               if (byte_done && byte_count_ff > srx_pkg::HDR_DEST_POS) begin
                  if (size_bad || size_ff == 8'd2) begin
                     phase_in = srx_pkg::PH_HUNT;
                  end else begin
                     phase_in = srx_pkg::PH_PAYLOAD;
                  end
               end
            end
            srx_pkg::PH_PAYLOAD: begin
               if (byte_done && (byte_count_ff + 8'd1) >= payload_len) begin
                  phase_in = srx_pkg::PH_HUNT;
               end
            end
            default: begin
               if (window_shift == preamble) begin
                  phase_in = srx_pkg::PH_HEADER;
               end
            end
         endcase
      end
   end

   // Datapath and results.
   always_comb begin
      window_in     = window_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      partial_in    = partial_ff;
      crc_rx_in     = crc_rx_ff;
      crc_run_in    = crc_run_ff;
      size_in       = size_ff;
      dest_in       = dest_ff;
      src_in        = src_ff;
      push          = '0;
      if (step_en) begin
         unique case (phase_ff) inside
            srx_pkg::PH_HEADER, srx_pkg::PH_PAYLOAD: begin
               bit_count_in = bit_count_ff + 3'd1;
               partial_in   = byte_done ? 8'd0 : byte_val;
               if (crc_active) begin
                  crc_run_in = crc_step;
               end
               if (byte_done && in_header) begin
                  byte_count_in = byte_count_ff + 8'd1;
                  if (byte_count_ff < srx_pkg::HDR_SIZE_POS) begin
                     case (byte_count_ff[1:0])
                        2'd0:    crc_rx_in[7:0]   = byte_val;
                        2'd1:    crc_rx_in[15:8]  = byte_val;
                        2'd2:    crc_rx_in[23:16] = byte_val;
                        default: crc_rx_in[31:24] = byte_val;
                     endcase
                  end else if (byte_count_ff == srx_pkg::HDR_SIZE_POS) begin
                     size_in = byte_val;
                  end else if (byte_count_ff == srx_pkg::HDR_DEST_POS) begin
                     dest_in = byte_val;
                  end else begin
                     src_in                    = byte_val;
                     byte_count_in             = 8'd0;
                     push.first.frame_crc      = crc_rx_ff;
                     push.first.frame_size     = size_ff;
                     push.first.dest_addr      = dest_ff;
                     push.first.src_addr       = byte_val;
                     push.first.last           = 1'b1;
                     if (size_bad) begin
                        push.count      = 2'd1;
                        push.first.kind = srx_pkg::KIND_SIZE_ERR;
                        window_in       = 8'd0;
                     end else if (size_ff == 8'd2) begin
                        push.count              = 2'd1;
                        push.first.kind         = srx_pkg::KIND_FRAME;
                        push.first.computed_crc = srx_pkg::swap32(crc_step);
                        push.first.crc_ok       = (srx_pkg::swap32(crc_step) == crc_rx_ff);
                        window_in               = 8'd0;
                     end
                  end
               end else if (byte_done) begin
                  byte_count_in        = byte_count_ff + 8'd1;
                  push.count           = 2'd1;
                  push.first.kind      = srx_pkg::KIND_PAYLOAD;
                  push.first.data_byte = byte_val;
                  if ((byte_count_ff + 8'd1) >= payload_len) begin
                     push.count               = 2'd2;
                     byte_count_in            = 8'd0;
                     window_in                = 8'd0;
                     push.second.kind         = srx_pkg::KIND_FRAME;
                     push.second.frame_crc    = crc_rx_ff;
                     push.second.computed_crc = srx_pkg::swap32(crc_step);
                     push.second.crc_ok       = (srx_pkg::swap32(crc_step) == crc_rx_ff);
                     push.second.frame_size   = size_ff;
                     push.second.dest_addr    = dest_ff;
                     push.second.src_addr     = src_ff;
                     push.second.last         = 1'b1;
                  end else begin
                     push.first.last = 1'b1;
                  end
               end
            end
            default: begin
               window_in = window_shift;
               if (window_shift == preamble) begin
                  bit_count_in  = 3'd0;
                  byte_count_in = 8'd0;
                  partial_in    = 8'd0;
                  crc_rx_in     = 32'd0;
                  crc_run_in    = 32'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= srx_pkg::PH_HUNT;
         window_ff     <= 8'd0;
         bit_count_ff  <= 3'd0;
         byte_count_ff <= 8'd0;
         partial_ff    <= 8'd0;
         crc_rx_ff     <= 32'd0;
         crc_run_ff    <= 32'd0;
         size_ff       <= 8'd0;
         dest_ff       <= 8'd0;
         src_ff        <= 8'd0;
      end else begin
         phase_ff      <= phase_in;
         window_ff     <= window_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         partial_ff    <= partial_in;
         crc_rx_ff     <= crc_rx_in;
         crc_run_ff    <= crc_run_in;
         size_ff       <= size_in;
         dest_ff       <= dest_in;
         src_ff        <= src_in;
      end
   end

endmodule

// File: rtl/core/srx_result_fifo.sv
// ============================================================================
// srx_result_fifo
// Small result queue taking up to two items per cycle and giving one.
// ============================================================================
module srx_result_fifo (
   input  logic                clock,
   input  logic                reset,
   input  srx_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_pop,
   output srx_pkg::result_type out_item
);

   srx_pkg::result_type entry_ff [srx_pkg::FIFO_DEPTH];
   logic [srx_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [srx_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [srx_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [srx_pkg::FIFO_PTR_W-1:0] wr_next;

   // Room for the worst case of two items from one bit.
   assign room      = (count_ff <= srx_pkg::FIFO_CNT_W'(srx_pkg::FIFO_DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign wr_next   = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + srx_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + srx_pkg::FIFO_PTR_W'(out_pop);
      count_in  = count_ff + srx_pkg::FIFO_CNT_W'(push.count)
                  - srx_pkg::FIFO_CNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/srx_checker.sv
// ============================================================================
// srx_checker
// Port-level checks on the serial frame receiver results.
// ============================================================================
module srx_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [7:0]  rsp_data_byte,
   input logic [31:0] rsp_frame_crc,
   input logic [31:0] rsp_computed_crc,
   input logic        rsp_crc_ok,
   input logic        rsp_last
);

   // A frame result flags a match exactly when both CRCs agree.
   a_crc_ok_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == srx_pkg::KIND_FRAME) |->
      (rsp_crc_ok == (rsp_frame_crc == rsp_computed_crc)))
      else $error("crc_ok does not match CRC comparison");

   // Payload items carry no CRC information.
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == srx_pkg::KIND_PAYLOAD) |->
      (rsp_frame_crc == 32'd0 && rsp_computed_crc == 32'd0 && !rsp_crc_ok))
      else $error("payload item carries CRC fields");

   // Frame and error results always close the results of their bit and carry a zero data byte.
   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == srx_pkg::KIND_FRAME || rsp_kind == srx_pkg::KIND_SIZE_ERR))
      |-> (rsp_last && rsp_data_byte == 8'd0))
      else $error("frame or error result without last");

   // A size error reports no computed CRC.
   a_err_no_crc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == srx_pkg::KIND_SIZE_ERR) |->
      (rsp_computed_crc == 32'd0 && !rsp_crc_ok))
      else $error("size error carries computed CRC");

   // A stalled result stays offered with its kind, data byte and last flag unchanged.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      (rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte) && $stable(rsp_last)))
      else $error("stalled result changed");

endmodule

bind serial_frame_receiver_crc32_top srx_checker u_srx_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_data_byte    (rsp_data_byte),
   .rsp_frame_crc    (rsp_frame_crc),
   .rsp_computed_crc (rsp_computed_crc),
   .rsp_crc_ok       (rsp_crc_ok),
   .rsp_last         (rsp_last)
);

// File: sim/testbench.sv
// ============================================================================
// Serial frame receiver testbench
// Feeds the deframer one data bit per item, builds frames around a preamble
// with good and bad CRCs and with legal and illegal sizes, predicts every
// payload byte, frame report and size error in a model of its own, and checks
// each result field by field while both channels idle and stall at random.
// ============================================================================
module testbench;
   import srx_pkg::*;

   // Generous ceiling on the run, counted in clock cycles.
   localparam int CYCLE_LIMIT  = 200_000;
   // Cycles allowed after the last result for a bit still inside the block.
   localparam int DRAIN_CYCLES = 4;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_data_bit;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [31:0] rsp_frame_crc;
   logic [31:0] rsp_computed_crc;
   logic        rsp_crc_ok;
   logic [7:0]  rsp_frame_size;
   logic [7:0]  rsp_dest_addr;
   logic [7:0]  rsp_src_addr;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [7:0]  csr_data;

   serial_frame_receiver_crc32_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_bit     (req_data_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_crc    (rsp_frame_crc),
      .rsp_computed_crc (rsp_computed_crc),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_frame_size   (rsp_frame_size),
      .rsp_dest_addr    (rsp_dest_addr),
      .rsp_src_addr     (rsp_src_addr),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // -------------------------------------------------------------------------
   // Shared bookkeeping
   // -------------------------------------------------------------------------
   int  error_count   = 0;
   int  cycle_count   = 0;
   int  framed_bits   = 0;    // bits taken while inside a frame
   int  result_count  = 0;    // results predicted so far
   bit  sender_fast   = 1'b0; // sender offers every item without a gap
   bit  receiver_fast = 1'b0; // receiver takes every item without a stall
   int  rsp_wait_left = 0;    // stall cycles still owed before the next item
   int  hold_request  = 0;    // long receiver hold-off, in cycles

   // Results still owed by the block, oldest first.
   result_type pending_results[$];

   // -------------------------------------------------------------------------
   // Deframer model: its own copy of the registers and of the frame state.
   // -------------------------------------------------------------------------
   logic [7:0]  cfg_preamble;
   logic [7:0]  cfg_max_len;
   phase_type   rx_phase;
   logic [7:0]  rx_window;
   logic [2:0]  bit_pos;
   logic [7:0]  byte_pos;
   logic [7:0]  shift_byte;
   logic [31:0] carried_crc;
   logic [31:0] running_crc;
   logic [7:0]  frame_len_byte;
   logic [7:0]  dest_byte;
   logic [7:0]  src_byte;

   // One byte of the MSB-first CRC-32, no reflection and no final inversion.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {data, 24'd0};
      for (int i = 0; i < 8; i++)
         c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
      return c;
   endfunction

   function automatic void reset_model();
      cfg_preamble   = PREAMBLE_RESET;
      cfg_max_len    = MAX_PAYLOAD_RESET;
      rx_phase       = PH_HUNT;
      rx_window      = '0;
      bit_pos        = '0;
      byte_pos       = '0;
      shift_byte     = '0;
      carried_crc    = '0;
      running_crc    = '0;
      frame_len_byte = '0;
      dest_byte      = '0;
      src_byte       = '0;
   endfunction

   function automatic void store_result(input result_type res);
      pending_results.push_back(res);
      result_count++;
   endfunction

   // The window is emptied as well, so the next frame needs a fresh match.
   function automatic void back_to_hunt();
      rx_phase  = PH_HUNT;
      rx_window = '0;
      bit_pos   = '0;
      byte_pos  = '0;
   endfunction

   function automatic result_type header_result(input logic [1:0] kind);
      result_type res;
      res              = '0;
      res.kind         = kind;
      res.frame_crc    = carried_crc;
      res.frame_size   = frame_len_byte;
      res.dest_addr    = dest_byte;
      res.src_addr     = src_byte;
      return res;
   endfunction

   function automatic result_type frame_result();
      result_type  res;
      logic [31:0] swapped;
      swapped          = {running_crc[7:0], running_crc[15:8],
                          running_crc[23:16], running_crc[31:24]};
      res              = header_result(KIND_FRAME);
      res.computed_crc = swapped;
      res.crc_ok       = (swapped == carried_crc);
      res.last         = 1'b1;
      return res;
   endfunction

   // Advances the model by one accepted bit and queues what it produces.
   function automatic void deframe_bit(input logic data_bit);
      logic [7:0] byte_val;
      logic [7:0] body_len;
      logic       frame_done;
      result_type res;
      // Anything other than header or payload counts as hunting.
      if (rx_phase != PH_HEADER && rx_phase != PH_PAYLOAD) begin
         rx_window = {rx_window[6:0], data_bit};
         if (rx_window == cfg_preamble) begin
            rx_phase    = PH_HEADER;
            bit_pos     = '0;
            byte_pos    = '0;
            shift_byte  = '0;
            carried_crc = '0;
         end
         return;
      end
      framed_bits++;
      shift_byte = {shift_byte[6:0], data_bit};
      bit_pos    = bit_pos + 3'd1;
      if (bit_pos != 3'd0)
         return;
      byte_val   = shift_byte;
      shift_byte = '0;
      if (rx_phase == PH_HEADER) begin
         if (byte_pos < HDR_SIZE_POS) begin
            carried_crc = carried_crc | ({24'd0, byte_val} << (8 * byte_pos));
         end else if (byte_pos == HDR_SIZE_POS) begin
            frame_len_byte = byte_val;
         end else if (byte_pos == HDR_DEST_POS) begin
            dest_byte = byte_val;
         end else begin
            src_byte = byte_val;
            body_len = frame_len_byte - 8'd2;
            if (frame_len_byte < 8'd2 || body_len > cfg_max_len) begin
               res      = header_result(KIND_SIZE_ERR);
               res.last = 1'b1;
               store_result(res);
               back_to_hunt();
               return;
            end
            running_crc = crc32_byte(crc32_byte(32'd0, dest_byte), src_byte);
            if (frame_len_byte == 8'd2) begin
               store_result(frame_result());
               back_to_hunt();
               return;
            end
            rx_phase = PH_PAYLOAD;
            byte_pos = '0;
            return;
         end
         byte_pos = byte_pos + 8'd1;
         return;
      end
      running_crc   = crc32_byte(running_crc, byte_val);
      byte_pos      = byte_pos + 8'd1;
      body_len      = frame_len_byte - 8'd2;
      frame_done    = (byte_pos >= body_len);
      res           = '0;
      res.kind      = KIND_PAYLOAD;
      res.data_byte = byte_val;
      res.last      = !frame_done;
      store_result(res);
      if (frame_done) begin
         store_result(frame_result());
         back_to_hunt();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Clock and run limit
   // -------------------------------------------------------------------------
   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : run_limit
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver side. The stall is changed only at the falling edge. After each
   // item taken a fresh stall length is drawn; a long hold-off, when asked
   // for, is counted out here, cycle by cycle.
   // -------------------------------------------------------------------------
   initial begin : receiver_pacing
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_request - 1) @(negedge clock);
            hold_request = 0;
         end else if (rsp_wait_left > 0) begin
            rsp_stall = 1'b1;
            rsp_wait_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Every result taken is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_wait_left = receiver_fast ? 0 : $urandom_range(0, 16);
         if (pending_results.size() == 0) begin
            $error("result of kind 0x%0h arrived with nothing expected", rsp_kind);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind",         32'(want.kind),       32'(rsp_kind));
            compare_field("data_byte",    32'(want.data_byte),  32'(rsp_data_byte));
            compare_field("frame_crc",    want.frame_crc,       rsp_frame_crc);
            compare_field("computed_crc", want.computed_crc,    rsp_computed_crc);
            compare_field("crc_ok",       32'(want.crc_ok),     32'(rsp_crc_ok));
            compare_field("frame_size",   32'(want.frame_size), 32'(rsp_frame_size));
            compare_field("dest_addr",    32'(want.dest_addr),  32'(rsp_dest_addr));
            compare_field("src_addr",     32'(want.src_addr),   32'(rsp_src_addr));
            compare_field("last",         32'(want.last),       32'(rsp_last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender side. Inputs change at the falling edge only. The valid is left
   // high after an item is taken, so a back-to-back item never lowers and
   // raises it within one time step.
   // -------------------------------------------------------------------------
   task automatic send_bit(input logic data_bit);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_data_bit = data_bit;
      do @(posedge clock); while (req_stall !== 1'b0);
      deframe_bit(data_bit);
   endtask

   task automatic send_byte(input logic [7:0] value);
      for (int i = 7; i >= 0; i--)
         send_bit(value[i]);
   endtask

   // Idles the input and waits until every expected result has been taken,
   // then waits out the drain allowance for any bit still in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle, so the model may follow at once.
   task automatic write_register(input logic index, input logic [7:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == CSR_PREAMBLE)
         cfg_preamble = value;
      else
         cfg_max_len = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Sends the preamble MSB first from bit lead_msb down, stopping as soon as
   // the window matches. Earlier bits or an emptied window can complete the
   // match early; if none happens the pattern is simply repeated.
   task automatic send_preamble(input int lead_msb);
      int i;
      i = lead_msb;
      while (rx_phase == PH_HUNT) begin
         send_bit(cfg_preamble[i]);
         i = (i == 0) ? 7 : i - 1;
      end
   endtask

   // Random bits that never complete the preamble, sent while hunting.
   task automatic send_noise(input int count);
      logic data_bit;
      repeat (count) begin
         data_bit = 1'($urandom_range(0, 1));
         if ({rx_window[6:0], data_bit} == cfg_preamble)
            data_bit = ~data_bit;
         send_bit(data_bit);
      end
   endtask

   // A whole frame. The payload is only sent when the size passes the check,
   // as the block goes back to hunting otherwise.
   task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] dest,
                             input logic [7:0] src, input bit good_crc,
                             input int lead_msb);
      logic [7:0]  body[$];
      logic [31:0] crc;
      logic [31:0] carried;
      int          body_count;
      body_count = 0;
      if (len_byte >= 8'd2 && int'(len_byte) - 2 <= int'(cfg_max_len))
         body_count = int'(len_byte) - 2;
      crc = crc32_byte(crc32_byte(32'd0, dest), src);
      repeat (body_count) begin
         body.push_back(8'($urandom_range(0, 255)));
         crc = crc32_byte(crc, body[$]);
      end
      // The carried CRC travels low byte first, so a match needs the swap.
      carried = good_crc ? {crc[7:0], crc[15:8], crc[23:16], crc[31:24]} : $urandom;
      send_preamble(lead_msb);
      send_byte(carried[7:0]);
      send_byte(carried[15:8]);
      send_byte(carried[23:16]);
      send_byte(carried[31:24]);
      send_byte(len_byte);
      send_byte(dest);
      send_byte(src);
      foreach (body[k])
         send_byte(body[k]);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Default preamble: an ordinary frame, then an empty payload with a bad
   // CRC whose preamble leans on the emptied window, so seven bits are enough.
   task automatic test_basic_frames();
      send_frame(8'd5, 8'h00, 8'hFF, 1'b1, 7);
      send_frame(8'd2, 8'h5A, 8'hA5, 1'b0, 6);
      wait_drained();
   endtask

   // Sizes below two and just beyond the payload limit give an error; with
   // the limit at zero even a single payload byte is refused.
   task automatic test_size_field();
      send_frame(8'd0, 8'h12, 8'h34, 1'b1, 7);
      send_frame(8'd251, 8'h00, 8'h00, 1'b1, 7);
      wait_drained();
      write_register(CSR_MAX_PAYLOAD, 8'd0);
      send_frame(8'd3, 8'h03, 8'h04, 1'b1, 7);
      wait_drained();
      write_register(CSR_MAX_PAYLOAD, MAX_PAYLOAD_RESET);
   endtask

   // All-zero and all-one preambles. An all-zero pattern matches the emptied
   // window on its very first bit.
   task automatic test_preamble_extremes();
      write_register(CSR_PREAMBLE, 8'h00);
      send_frame(8'd3, 8'hFF, 8'h00, 1'b1, 7);
      wait_drained();
      write_register(CSR_PREAMBLE, 8'hFF);
      send_frame(8'd2, 8'hFF, 8'hFF, 1'b1, 7);
      wait_drained();
      write_register(CSR_PREAMBLE, PREAMBLE_RESET);
   endtask

   // The receiver holds off for a long stretch while bits keep coming at full
   // rate, so the result queue fills and the input is stalled. Afterwards the
   // sender pauses until everything has come out.
   task automatic test_input_backpressure();
      hold_request = 300;
      sender_fast  = 1'b1;
      send_frame(8'd8, 8'h6B, 8'h94, 1'b1, 7);
      sender_fast  = 1'b0;
      wait_drained();
   endtask

   // Mostly well-formed frames with random content and short payloads, mixed
   // with noise, bad sizes and bad CRCs, under a random preamble with the
   // payload limit first at its top and then at a random value.
   task automatic test_random_traffic();
      int         bits_mark;
      int         results_mark;
      int         pick;
      int         body_top;
      int         body_len;
      logic [7:0] len_byte;
      for (int setting = 0; setting < 2; setting++) begin
         wait_drained();
         write_register(CSR_PREAMBLE, 8'($urandom_range(0, 255)));
         if (setting == 0)
            write_register(CSR_MAX_PAYLOAD, 8'd253);
         else
            write_register(CSR_MAX_PAYLOAD, 8'($urandom_range(1, 252)));
         bits_mark    = framed_bits;
         results_mark = result_count;
         while (framed_bits - bits_mark < 56 || result_count - results_mark < 3) begin
            sender_fast   = ($urandom_range(0, 3) == 0);
            receiver_fast = ($urandom_range(0, 3) == 0);
            pick          = $urandom_range(0, 99);
            if (pick < 12) begin
               send_noise($urandom_range(1, 24));
            end else if (pick < 24) begin
               if (cfg_max_len >= 8'd253 || $urandom_range(0, 1) == 0)
                  len_byte = 8'($urandom_range(0, 1));
               else
                  len_byte = 8'($urandom_range(int'(cfg_max_len) + 3, 255));
               send_frame(len_byte, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b1, 7);
            end else begin
               body_top = (cfg_max_len < 8'd6) ? int'(cfg_max_len) : 6;
               body_len = $urandom_range(0, body_top);
               send_frame(8'(body_len + 2), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), ($urandom_range(0, 9) < 7), 7);
            end
            if ($urandom_range(0, 19) == 0)
               wait_drained();
         end
      end
      sender_fast   = 1'b0;
      receiver_fast = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data_bit = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = CSR_PREAMBLE;
      csr_data     = '0;
      reset_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_frames();
      test_size_field();
      test_preamble_extremes();
      test_input_backpressure();
      test_random_traffic();

      // Nothing may be left owing, and nothing stray may follow.
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/srx_pkg.sv
rtl/core/srx_deframer.sv
rtl/core/srx_result_fifo.sv
rtl/core/serial_frame_receiver_crc32_top.sv
rtl/core/srx_checker.sv
sim/testbench.sv
